// ===== rtl/core/cbb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants of the canvas brush and box blur unit
// Transaction payloads, item kinds, brush constants and the fixed-point
// reciprocal that replaces the divide by nine.
// ----------------------------------------------------------------------------
package cbb_pkg;

  typedef enum logic [1:0] {
    KIND_STAMP = 2'd0,
    KIND_BLUR  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] cursor_x;
    logic [5:0] cursor_y;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       rejected;
  } result_t;

  // One tap of the blur sweep, as it comes back from the canvas memory.
  typedef struct packed {
    logic active;
    logic in_bounds;
    logic last_tap;
    logic first_col;
    logic emit;
  } tap_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } blur_res_t;

  localparam logic [7:0] PENCIL_CENTER = 8'd87;
  localparam logic [7:0] PENCIL_EDGE   = 8'd123;
  localparam logic [7:0] FULL_WHITE    = 8'd255;

  // floor(n / 9) == (n * 3641) >> 15 for every n below 32768.
  localparam logic [11:0] BLUR_RECIP = 12'd3641;
  localparam int          BLUR_SHIFT = 15;

  localparam logic [2:0] REG_BRUSH_MODE_ADDR = 3'd0;

endpackage
`default_nettype wire

// ===== rtl/core/cbb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 784
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/cbb_blur_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_blur_acc: column-sum accumulator and divide-by-nine for the box blur
// Adds three vertical taps into a column sum, keeps a window of three column
// sums and turns each window total into its quotient by nine.
// ----------------------------------------------------------------------------
module cbb_blur_acc
  import cbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire tap_t       tap,
  input  wire logic [7:0] rd_data,
  output      blur_res_t  res
);

  logic [9:0]  acc;
  logic [9:0]  win_a;
  logic [9:0]  win_b;
  logic [9:0]  tap_val;
  logic [9:0]  colsum;
  logic [11:0] sum_q;
  logic        sum_vld;
  logic [23:0] prod;
  logic [7:0]  quot;
  logic        quot_vld;

  assign tap_val = tap.in_bounds ? {2'b00, rd_data} : 10'd0;
  assign colsum  = acc + tap_val;
  assign prod    = sum_q * BLUR_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      sum_vld  <= 1'b0;
      quot_vld <= 1'b0;
    end else begin
      sum_vld  <= tap.active && tap.last_tap && tap.emit;
      quot_vld <= sum_vld;
      if (tap.active) begin
        acc <= tap.last_tap ? 10'd0 : colsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tap.active && tap.last_tap) begin
      // The column left of the first column lies outside the canvas.
      win_a <= tap.first_col ? 10'd0 : win_b;
      win_b <= colsum;
      sum_q <= {2'b00, win_a} + {2'b00, win_b} + {2'b00, colsum};
    end
    quot <= prod[BLUR_SHIFT +: 8];
  end

  assign res.valid = quot_vld;
  assign res.value = quot;

endmodule
`default_nettype wire

// ===== rtl/core/canvas_brush_and_box_blur_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// canvas_brush_and_box_blur_unit: grey canvas with 2x2 brush and 3x3 box blur
// Keeps a SIDE x SIDE canvas of 8-bit pixels in two banks of memory.
// ----------------------------------------------------------------------------
// One item is processed at a time and item_ready is high only while the unit
// is idle. The sequencer uses the single read port of the canvas memory once
// per cycle. A rejected stamp or read is answered from idle. After reset a
// clearing pass runs with item_ready low; configuration writes are taken at
// all times. The blur writes its results into the other bank and then swaps
// banks.
module canvas_brush_and_box_blur_unit
  import cbb_pkg::*;
#(
  parameter int SIDE = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output      logic        item_ready,
  input  wire item_t       item,
  output      logic        result_valid,
  input  wire logic        result_ready,
  output      result_t     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int AREA = SIDE * SIDE;
  localparam int AW   = $clog2(AREA);
  localparam int YW   = $clog2(SIDE);
  localparam int CW   = $clog2(SIDE + 1);

  localparam logic [AW-1:0] SideA    = AW'(SIDE);
  localparam logic [AW-1:0] LastAddr = AW'(AREA - 1);
  localparam logic [CW-1:0] SideC    = CW'(SIDE);
  localparam logic [YW-1:0] LastY    = YW'(SIDE - 1);
  localparam logic [5:0]    LastX6   = 6'(SIDE - 1);
  localparam logic [6:0]    Side7    = 7'(SIDE);

  localparam logic [1:0] TAP_ABOVE = 2'd0;
  localparam logic [1:0] TAP_MID   = 2'd1;
  localparam logic [1:0] TAP_BELOW = 2'd2;

  localparam logic [1:0] ST_CENTER = 2'd0;
  localparam logic [1:0] ST_RIGHT  = 2'd1;
  localparam logic [1:0] ST_DOWN   = 2'd2;
  localparam logic [1:0] ST_DIAG   = 2'd3;

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CLEAR    = 9'b000000100,
    S_STAMP_RD = 9'b000001000,
    S_STAMP_WR = 9'b000010000,
    S_READ_RD  = 9'b000100000,
    S_READ_WR  = 9'b001000000,
    S_BLUR     = 9'b010000000,
    S_DRAIN    = 9'b100000000
  } state_t;

  // S_DONE is folded into a flag so the enum stays small.
  state_t state;
  state_t state_next;
  logic   done;

  logic          brush_mode;
  logic          bank;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] st_base;
  logic          st_right;
  logic          st_down;
  logic [1:0]    st_k;
  logic [AW-1:0] st_addr;
  logic          st_exists;
  logic [7:0]    st_value;
  logic [8:0]    sum_center;
  logic [8:0]    sum_edge;

  logic [YW-1:0] row_y;
  logic [CW-1:0] col_c;
  logic [1:0]    tap_r;
  logic [AW-1:0] row_base;
  logic [AW-1:0] center;
  logic [AW-1:0] blur_addr;
  logic          blur_inb;
  logic          blur_last;
  logic [1:0]    drain_cnt;
  tap_t          tap_d;
  logic [AW-1:0] waddr_d;
  logic [AW-1:0] waddr_m;
  logic [AW-1:0] waddr_w;
  blur_res_t     blur_res;

  logic [7:0] res_pix;
  logic       res_rej;

  logic          in_canvas;
  logic          accept;

  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [7:0]    rdata_a;
  logic [7:0]    rdata_b;
  logic          cur_we;
  logic [AW-1:0] cur_waddr;
  logic [7:0]    cur_wdata;
  logic          we_a;
  logic          we_b;
  logic [AW-1:0] waddr_a;
  logic [AW-1:0] waddr_b;
  logic [7:0]    wdata_a;
  logic [7:0]    wdata_b;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_BRUSH_MODE_ADDR) ? {31'd0, brush_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == REG_BRUSH_MODE_ADDR)) begin
      brush_mode <= pwdata[0];
    end
  end

  // Item decode
  assign item_ready = (state == S_IDLE) && !done;
  assign accept     = item_valid && item_ready;
  assign in_canvas  = ({1'b0, item.cursor_x} < Side7) && ({1'b0, item.cursor_y} < Side7);

  // Stamp datapath
  always_comb begin
    st_addr    = st_base;
    st_exists  = 1'b1;
    sum_center = {1'b0, rdata} + {1'b0, PENCIL_CENTER};
    sum_edge   = {1'b0, rdata} + {1'b0, PENCIL_EDGE};
    st_value   = sum_center[8] ? FULL_WHITE : sum_center[7:0];
    case (st_k)
      ST_RIGHT: begin
        st_addr   = st_base + AW'(1);
        st_exists = st_right;
        st_value  = sum_edge[8] ? FULL_WHITE : sum_edge[7:0];
      end
      ST_DOWN: begin
        st_addr   = st_base + SideA;
        st_exists = st_down;
        st_value  = sum_edge[8] ? FULL_WHITE : sum_edge[7:0];
      end
      ST_DIAG: begin
        st_addr   = st_base + SideA + AW'(1);
        st_exists = st_right && st_down;
        st_value  = FULL_WHITE;
      end
      default: begin
      end
    endcase
    if (brush_mode) begin
      st_value = 8'd0;
    end
  end

  // Blur read addressing
  always_comb begin
    center   = row_base + AW'(col_c);
    blur_inb = (col_c != SideC)
               && !((tap_r == TAP_ABOVE) && (row_y == '0))
               && !((tap_r == TAP_BELOW) && (row_y == LastY));
    case (tap_r)
      TAP_ABOVE: blur_addr = center - SideA;
      TAP_BELOW: blur_addr = center + SideA;
      TAP_MID:   blur_addr = center;
      default:   blur_addr = center;
    endcase
    if (!blur_inb) begin
      blur_addr = '0;
    end
    blur_last = (tap_r == TAP_BELOW) && (col_c == SideC) && (row_y == LastY);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (clr_addr == LastAddr) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_STAMP: state_next = in_canvas ? S_STAMP_RD : S_IDLE;
            KIND_BLUR:  state_next = S_BLUR;
            KIND_CLEAR: state_next = S_CLEAR;
            KIND_READ:  state_next = in_canvas ? S_READ_RD : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_addr == LastAddr) state_next = S_IDLE;
      end
      S_STAMP_RD: state_next = S_STAMP_WR;
      S_STAMP_WR: state_next = (st_k == ST_DIAG) ? S_IDLE : S_STAMP_RD;
      S_READ_RD:  state_next = S_READ_WR;
      S_READ_WR:  state_next = S_IDLE;
      S_BLUR: begin
        if (blur_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_cnt == 2'd2) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      done         <= 1'b0;
      bank         <= 1'b0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      tap_d        <= '0;
    end else begin
      state <= state_next;

      tap_d.active    <= (state == S_BLUR);
      tap_d.in_bounds <= blur_inb;
      tap_d.last_tap  <= (tap_r == TAP_BELOW);
      tap_d.first_col <= (col_c == '0);
      tap_d.emit      <= (col_c != '0);

      if ((state == S_INIT) || (state == S_CLEAR)) begin
        clr_addr <= (clr_addr == LastAddr) ? '0 : clr_addr + AW'(1);
      end

      // An item is done when rejected or when the sequencer returns to idle from a
      // working state; the result then waits for a free output register.
      if (((state == S_IDLE) && accept && !in_canvas
           && ((item.kind == KIND_STAMP) || (item.kind == KIND_READ)))
          || ((state == S_CLEAR) && (clr_addr == LastAddr))
          || ((state == S_STAMP_WR) && (st_k == ST_DIAG))
          || (state == S_READ_WR)
          || ((state == S_DRAIN) && (drain_cnt == 2'd2))) begin
        done <= 1'b1;
      end

      if (done && (!result_valid || result_ready)) begin
        done         <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      if ((state == S_DRAIN) && (drain_cnt == 2'd2)) begin
        bank <= ~bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_pix  <= 8'd0;
      res_rej  <= ((item.kind == KIND_STAMP) || (item.kind == KIND_READ)) && !in_canvas;
      st_base  <= AW'(item.cursor_y) * SideA + AW'(item.cursor_x);
      st_right <= (item.cursor_x != LastX6);
      st_down  <= (item.cursor_y != LastX6);
      st_k     <= ST_CENTER;
      row_y    <= '0;
      col_c    <= '0;
      tap_r    <= TAP_ABOVE;
      row_base <= '0;
      drain_cnt <= 2'd0;
    end
    if (state == S_STAMP_WR) begin
      st_k <= st_k + 2'd1;
    end
    if (state == S_READ_WR) begin
      res_pix <= rdata;
    end
    if (state == S_BLUR) begin
      if (tap_r == TAP_BELOW) begin
        tap_r <= TAP_ABOVE;
        if (col_c == SideC) begin
          col_c    <= '0;
          row_y    <= row_y + YW'(1);
          row_base <= row_base + SideA;
        end else begin
          col_c <= col_c + CW'(1);
        end
      end else begin
        tap_r <= tap_r + 2'd1;
      end
    end
    if (state == S_DRAIN) begin
      drain_cnt <= drain_cnt + 2'd1;
    end
    if (done && (!result_valid || result_ready)) begin
      result.pixel_value <= res_pix;
      result.rejected    <= res_rej;
    end
    // Write address of the pixel left of the column just read.
    waddr_d <= center - AW'(1);
    waddr_m <= waddr_d;
    waddr_w <= waddr_m;
  end

  // Memory port selection
  always_comb begin
    raddr     = '0;
    cur_we    = 1'b0;
    cur_waddr = clr_addr;
    cur_wdata = 8'd0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        cur_we = 1'b1;
      end
      S_STAMP_RD: begin
        raddr = st_exists ? st_addr : '0;
      end
      S_STAMP_WR: begin
        cur_we    = st_exists;
        cur_waddr = st_addr;
        cur_wdata = st_value;
      end
      S_READ_RD: begin
        raddr = st_base;
      end
      S_BLUR: begin
        raddr = blur_addr;
      end
      default: begin
      end
    endcase
  end

  assign rdata   = bank ? rdata_b : rdata_a;
  assign we_a    = bank ? blur_res.valid : cur_we;
  assign we_b    = bank ? cur_we : blur_res.valid;
  assign waddr_a = bank ? waddr_w : cur_waddr;
  assign waddr_b = bank ? cur_waddr : waddr_w;
  assign wdata_a = bank ? blur_res.value : cur_wdata;
  assign wdata_b = bank ? cur_wdata : blur_res.value;

  cbb_ram #(
    .WIDTH(8),
    .DEPTH(AREA)
  ) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  cbb_ram #(
    .WIDTH(8),
    .DEPTH(AREA)
  ) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  cbb_blur_acc u_blur_acc (
    .clk     (clk),
    .rst     (rst),
    .tap     (tap_d),
    .rd_data (rdata),
    .res     (blur_res)
  );

`ifndef SYNTH
  // The banks swap only when a blur has drained its last write.
  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    !$stable(bank) |-> $past(state == S_DRAIN))
    else $error("canvas bank swapped outside the end of a blur");

  // Blur results appear only while a blur is in flight.
  a_blur_write: assert property (@(posedge clk) disable iff (rst)
    blur_res.valid |-> ((state == S_BLUR) || (state == S_DRAIN)))
    else $error("blur result outside a blur transaction");

  // Never both banks written in the same cycle.
  a_one_bank: assert property (@(posedge clk) disable iff (rst)
    !(we_a && we_b))
    else $error("both canvas banks written at once");

  // A rejected transaction carries a zero pixel.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.rejected) |-> (result.pixel_value == 8'd0))
    else $error("rejected result with a nonzero pixel");
`endif

endmodule
`default_nettype wire
